// File: rtl/scan_path_beam_interpolator_assert.svh
// assertion helpers used by spbi_dpath
`ifndef SCAN_PATH_BEAM_INTERPOLATOR_ASSERT_SVH
`define SCAN_PATH_BEAM_INTERPOLATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SPBI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spbi: same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SPBI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spbi: next-cycle check failed");

`endif

// File: rtl/spbi_pkg.sv
`timescale 1ns / 1ps

package spbi_pkg;

  // segment table size and derived widths
  localparam int MAX_SEGMENTS = 256;
  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = AW + 1;

  // field widths
  localparam int TIME_W = 40;
  localparam int POS_W  = 32;
  localparam int POW_W  = 24;

  // arithmetic unit widths
  localparam int SQ_W       = 66;
  localparam int ROOT_W     = 34;
  localparam int ROOT_STEPS = 33;
  localparam int DIV_W      = 55;
  localparam int AX_STEPS   = 32;
  localparam int STEP_W     = 6;
  localparam int PROD_W     = 72;
  localparam int EL_HALF    = 20;

  // stream widths
  localparam int IN_DATA_W  = 200;
  localparam int OUT_DATA_W = 120;
  localparam int USER_W     = 2;

  localparam logic [TIME_W-1:0] MAX_TIME = {TIME_W{1'b1}};

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_ZERO_SPEED = 2'd2,
    STAT_BEAM_OFF   = 2'd3
  } status_t;

  typedef struct packed {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [POS_W-1:0]  z;
    logic [POW_W-1:0]  power;
    logic              mode;
    logic              zero_dwell;
    logic [TIME_W-1:0] end_time;
  } row_t;

  // controller to datapath
  typedef struct packed {
    logic    accept;
    logic    decode;
    logic    sq_step;
    logic    root_load;
    logic    dur_load;
    logic    commit;
    logic    walk_rd;
    logic    walk_ev;
    logic    cur_rd;
    logic    prv_rd;
    logic    prv_cap;
    logic    select;
    logic    mul_lo;
    logic    mul_hi;
    logic    ax_load;
    logic    ax_store;
    logic    res_load;
    status_t res_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_query;
    logic full;
    logic zero_speed;
    logic is_dwell;
    logic past_end;
    logic sq_done;
    logic root_done;
    logic div_done;
    logic walk_more;
    logic lin_move;
    logic axis_last;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/spbi_ram.sv
`timescale 1ns / 1ps

module spbi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/spbi_ctrl.sv
`timescale 1ns / 1ps

module spbi_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  spbi_pkg::stat_t st,
  output spbi_pkg::cmd_t  cmd
);
  import spbi_pkg::*;

  typedef enum logic [19:0] {
    ST_IDLE     = 20'h00001,
    ST_DECODE   = 20'h00002,
    ST_SQR      = 20'h00004,
    ST_ROOT_LD  = 20'h00008,
    ST_ROOT     = 20'h00010,
    ST_DUR_LD   = 20'h00020,
    ST_DUR      = 20'h00040,
    ST_COMMIT   = 20'h00080,
    ST_WALK_RD  = 20'h00100,
    ST_WALK_EV  = 20'h00200,
    ST_CUR_RD   = 20'h00400,
    ST_PRV_RD   = 20'h00800,
    ST_PRV_CAP  = 20'h01000,
    ST_SELECT   = 20'h02000,
    ST_MUL_LO   = 20'h04000,
    ST_MUL_HI   = 20'h08000,
    ST_AX_LD    = 20'h10000,
    ST_AX_DIV   = 20'h20000,
    ST_AX_STORE = 20'h40000,
    ST_RESULT   = 20'h80000
  } state_t;

  state_t  state_r, state_nxt;
  status_t res_r, res_nxt;

  assign in_tready = (state_r == ST_IDLE);

  // sequencing of one request
  always_comb begin
    cmd            = '0;
    state_nxt      = state_r;
    res_nxt        = res_r;
    cmd.res_status = res_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        if (st.is_query) begin
          if (st.past_end) begin
            res_nxt   = STAT_BEAM_OFF;
            state_nxt = ST_RESULT;
          end else begin
            state_nxt = ST_WALK_RD;
          end
        end else if (st.full) begin
          res_nxt   = STAT_FULL;
          state_nxt = ST_RESULT;
        end else if (st.zero_speed) begin
          res_nxt   = STAT_ZERO_SPEED;
          state_nxt = ST_RESULT;
        end else if (st.is_dwell) begin
          state_nxt = ST_COMMIT;
        end else begin
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        cmd.sq_step = 1'b1;
        if (st.sq_done) begin
          state_nxt = ST_ROOT_LD;
        end
      end
      ST_ROOT_LD: begin
        cmd.root_load = 1'b1;
        state_nxt     = ST_ROOT;
      end
      ST_ROOT: begin
        if (st.root_done) begin
          state_nxt = ST_DUR_LD;
        end
      end
      ST_DUR_LD: begin
        cmd.dur_load = 1'b1;
        state_nxt    = ST_DUR;
      end
      ST_DUR: begin
        if (st.div_done) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        res_nxt    = STAT_OK;
        state_nxt  = ST_RESULT;
      end
      ST_WALK_RD: begin
        cmd.walk_rd = 1'b1;
        state_nxt   = ST_WALK_EV;
      end
      ST_WALK_EV: begin
        cmd.walk_ev = 1'b1;
        state_nxt   = st.walk_more ? ST_WALK_RD : ST_CUR_RD;
      end
      ST_CUR_RD: begin
        cmd.cur_rd = 1'b1;
        state_nxt  = ST_PRV_RD;
      end
      ST_PRV_RD: begin
        cmd.prv_rd = 1'b1;
        state_nxt  = ST_PRV_CAP;
      end
      ST_PRV_CAP: begin
        cmd.prv_cap = 1'b1;
        state_nxt   = ST_SELECT;
      end
      ST_SELECT: begin
        cmd.select = 1'b1;
        res_nxt    = STAT_OK;
        state_nxt  = st.lin_move ? ST_MUL_LO : ST_RESULT;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_AX_LD;
      end
      ST_AX_LD: begin
        cmd.ax_load = 1'b1;
        state_nxt   = ST_AX_DIV;
      end
      ST_AX_DIV: begin
        if (st.div_done) begin
          state_nxt = ST_AX_STORE;
        end
      end
      ST_AX_STORE: begin
        cmd.ax_store = 1'b1;
        state_nxt    = st.axis_last ? ST_RESULT : ST_MUL_LO;
      end
      ST_RESULT: begin
        if (st.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      res_r   <= STAT_OK;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

endmodule

// File: rtl/spbi_dpath.sv
`timescale 1ns / 1ps
`include "scan_path_beam_interpolator_assert.svh"

module spbi_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spbi_pkg::cmd_t                cmd,
  output spbi_pkg::stat_t               st,
  input  logic                          in_func,
  input  logic                          in_seg_mode,
  input  logic [spbi_pkg::POS_W-1:0]    in_pos_x,
  input  logic [spbi_pkg::POS_W-1:0]    in_pos_y,
  input  logic [spbi_pkg::POS_W-1:0]    in_pos_z,
  input  logic [spbi_pkg::POW_W-1:0]    in_seg_power,
  input  logic [spbi_pkg::TIME_W-1:0]   in_seg_param,
  input  logic [spbi_pkg::TIME_W-1:0]   in_query_time,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output spbi_pkg::status_t             out_status,
  output logic [spbi_pkg::POS_W-1:0]    out_beam_x,
  output logic [spbi_pkg::POS_W-1:0]    out_beam_y,
  output logic [spbi_pkg::POS_W-1:0]    out_beam_z,
  output logic [spbi_pkg::POW_W-1:0]    out_beam_power
);
  import spbi_pkg::*;

  typedef enum logic [1:0] {
    PH_BACK = 2'd0,
    PH_FWD  = 2'd1,
    PH_SKIP = 2'd2
  } phase_t;

  // signed difference of two Q16.16 values, 33 bits
  function automatic logic [POS_W:0] pos_diff(input logic [POS_W-1:0] a,
                                              input logic [POS_W-1:0] b);
    return {a[POS_W-1], a} - {b[POS_W-1], b};
  endfunction

  // magnitude of such a difference always fits 32 bits
  function automatic logic [POS_W-1:0] mag(input logic [POS_W:0] d);
    logic [POS_W:0] n;
    n = d[POS_W] ? (~d + 1'b1) : d;
    return n[POS_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] axis_of(input row_t r, input logic [1:0] a);
    logic [POS_W-1:0] v;
    case (a)
      2'd0:    v = r.x;
      2'd1:    v = r.y;
      default: v = r.z;
    endcase
    return v;
  endfunction

  // latched request
  logic              func_r, mode_r;
  logic [POS_W-1:0]  x_r, y_r, z_r;
  logic [POW_W-1:0]  pow_r;
  logic [TIME_W-1:0] param_r, qt_r;

  // path state
  logic [CW-1:0]     count_r;
  logic [AW-1:0]     pidx_r;
  logic [TIME_W-1:0] lpt_r, last_end_r;
  logic [POS_W-1:0]  last_x_r, last_y_r, last_z_r;
  logic [POS_W-1:0]  held_x_r, held_y_r, held_z_r;
  logic [POW_W-1:0]  held_pow_r;

  // query working registers
  logic [AW-1:0]     wi_r;
  phase_t            phase_r;
  row_t              cur_r, prv_r;
  logic [TIME_W-1:0] dt_r, el_r;
  logic [1:0]        axis_r;
  logic [PROD_W-1:0] prod_r;

  // sum of squares and root
  logic [1:0]        sq_cnt_r;
  logic [2*POS_W-1:0] sq_r;
  logic [SQ_W-1:0]   acc_r, op_r, res_r, one_r;
  logic [STEP_W-1:0] root_cnt_r;

  // shared restoring divider
  logic [TIME_W-1:0] rem_r, d_r;
  logic [DIV_W-1:0]  num_r, q_r;
  logic [STEP_W-1:0] div_cnt_r;

  // output stage
  logic              out_valid_r;
  status_t           out_status_r;
  logic [POS_W-1:0]  out_x_r, out_y_r, out_z_r;
  logic [POW_W-1:0]  out_pow_r;

  // table memory
  logic              rd_zero_r;
  logic [AW-1:0]     raddr, n_idx, ifin;
  logic [$bits(row_t)-1:0] rdata;
  row_t              rd_row, wr_row;

  // append end time
  logic [TIME_W-1:0] dur, new_end;
  logic [TIME_W:0]   end_sum;

  assign n_idx = AW'(count_r - CW'(1));
  assign ifin  = (wi_r == '0) ? AW'(1) : wi_r;

  always_comb begin
    case (1'b1)
      cmd.walk_rd: raddr = wi_r;
      cmd.cur_rd:  raddr = ifin;
      cmd.prv_rd:  raddr = pidx_r - AW'(1);
      default:     raddr = wi_r;
    endcase
  end

  // entry 0 is the origin and is never written
  assign rd_row = rd_zero_r ? row_t'('0) : row_t'(rdata);

  always_comb begin
    wr_row            = '0;
    wr_row.x          = x_r;
    wr_row.y          = y_r;
    wr_row.z          = z_r;
    wr_row.power      = pow_r;
    wr_row.mode       = mode_r;
    wr_row.zero_dwell = mode_r && (param_r == '0);
    wr_row.end_time   = new_end;
  end

  spbi_ram #(.WIDTH($bits(row_t)), .DEPTH(MAX_SEGMENTS)) u_table (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (count_r[AW-1:0]),
    .wdata (wr_row),
    .raddr (raddr),
    .rdata (rdata)
  );

  // append end time with saturation
  always_comb begin
    if (mode_r) begin
      dur = param_r;
    end else if (|q_r[DIV_W-1:TIME_W]) begin
      dur = MAX_TIME;
    end else begin
      dur = q_r[TIME_W-1:0];
    end
    end_sum = {1'b0, last_end_r} + {1'b0, dur};
    new_end = end_sum[TIME_W] ? MAX_TIME : end_sum[TIME_W-1:0];
  end

  // squared axis difference
  logic [POS_W-1:0] sq_mag;
  always_comb begin
    case (sq_cnt_r)
      2'd0:    sq_mag = mag(pos_diff(x_r, last_x_r));
      2'd1:    sq_mag = mag(pos_diff(y_r, last_y_r));
      2'd2:    sq_mag = mag(pos_diff(z_r, last_z_r));
      default: sq_mag = '0;
    endcase
  end

  // one root step
  logic [SQ_W:0] root_sum;
  logic          root_ge;
  assign root_sum = {1'b0, res_r} + {1'b0, one_r};
  assign root_ge  = {1'b0, op_r} >= root_sum;

  // one divider step
  logic [TIME_W:0] div_rs, div_sub;
  logic            div_ge;
  assign div_rs  = {rem_r, num_r[DIV_W-1]};
  assign div_ge  = div_rs >= {1'b0, d_r};
  assign div_sub = div_rs - {1'b0, d_r};

  // index walk decision
  logic walk_back, walk_fwd, walk_skip;
  always_comb begin
    walk_back = (phase_r == PH_BACK) && (wi_r != '0) && (rd_row.end_time > qt_r);
    walk_fwd  = !walk_back && (phase_r != PH_SKIP) && (wi_r < n_idx) &&
                (rd_row.end_time < qt_r);
    walk_skip = !walk_back && !walk_fwd && (wi_r < n_idx) &&
                rd_row.mode && rd_row.zero_dwell;
  end

  // interpolation per axis
  logic [POS_W:0]    ax_d;
  logic [POS_W-1:0]  ax_m, ax_p0, ax_val;
  logic [TIME_W-1:0] sel_dt, sel_el;
  logic              sel_after;
  logic [POS_W+EL_HALF-1:0] pp_lo, pp_hi;
  always_comb begin
    ax_p0     = axis_of(prv_r, axis_r);
    ax_d      = pos_diff(axis_of(cur_r, axis_r), ax_p0);
    ax_m      = mag(ax_d);
    pp_lo     = ax_m * el_r[EL_HALF-1:0];
    pp_hi     = ax_m * el_r[TIME_W-1:EL_HALF];
    ax_val    = ax_d[POS_W] ? (ax_p0 - q_r[POS_W-1:0]) : (ax_p0 + q_r[POS_W-1:0]);
    sel_dt    = cur_r.end_time - prv_r.end_time;
    sel_after = qt_r > prv_r.end_time;
    sel_el    = sel_after ? (qt_r - prv_r.end_time) : '0;
    if (sel_el > sel_dt) begin
      sel_el = sel_dt;
    end
  end

  // status to the controller
  always_comb begin
    st.is_query   = func_r;
    st.full       = (count_r == CW'(MAX_SEGMENTS));
    st.zero_speed = !mode_r && (param_r == '0);
    st.is_dwell   = mode_r;
    st.past_end   = (count_r <= CW'(1)) || (qt_r > lpt_r);
    st.sq_done    = (sq_cnt_r == 2'd3);
    st.root_done  = (root_cnt_r == '0);
    st.div_done   = (div_cnt_r == '0);
    st.walk_more  = walk_back || walk_fwd || walk_skip;
    st.lin_move   = !cur_r.mode && (sel_dt != '0);
    st.axis_last  = (axis_r == 2'd2);
    st.out_free   = !out_valid_r || out_tready;
  end

  // control and path state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= CW'(1);
      pidx_r      <= '0;
      lpt_r       <= '0;
      last_end_r  <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      last_z_r    <= '0;
      held_x_r    <= '0;
      held_y_r    <= '0;
      held_z_r    <= '0;
      held_pow_r  <= '0;
      root_cnt_r  <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      rd_zero_r   <= 1'b1;
    end else begin
      rd_zero_r <= (raddr == '0);
      if (cmd.commit) begin
        count_r    <= count_r + CW'(1);
        last_end_r <= new_end;
        last_x_r   <= x_r;
        last_y_r   <= y_r;
        last_z_r   <= z_r;
        if (pow_r != '0) begin
          lpt_r <= new_end;
        end
      end
      if (cmd.cur_rd) begin
        pidx_r <= ifin;
      end
      // positions and power of a finished query
      if (cmd.select) begin
        held_pow_r <= sel_after ? cur_r.power : prv_r.power;
        if (cur_r.mode) begin
          held_x_r <= cur_r.x;
          held_y_r <= cur_r.y;
          held_z_r <= cur_r.z;
        end else if (sel_dt == '0) begin
          held_x_r <= prv_r.x;
          held_y_r <= prv_r.y;
          held_z_r <= prv_r.z;
        end
      end
      if (cmd.ax_store) begin
        case (axis_r)
          2'd0:    held_x_r <= ax_val;
          2'd1:    held_y_r <= ax_val;
          default: held_z_r <= ax_val;
        endcase
      end
      if (cmd.res_load && (cmd.res_status == STAT_BEAM_OFF)) begin
        held_pow_r <= '0;
      end
      // unit step counters
      if (cmd.root_load) begin
        root_cnt_r <= STEP_W'(ROOT_STEPS);
      end else if (root_cnt_r != '0) begin
        root_cnt_r <= root_cnt_r - STEP_W'(1);
      end
      if (cmd.dur_load) begin
        div_cnt_r <= STEP_W'(DIV_W);
      end else if (cmd.ax_load) begin
        div_cnt_r <= STEP_W'(AX_STEPS);
      end else if (div_cnt_r != '0) begin
        div_cnt_r <= div_cnt_r - STEP_W'(1);
      end
      // output register
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r  <= in_func;
      mode_r  <= in_seg_mode;
      x_r     <= in_pos_x;
      y_r     <= in_pos_y;
      z_r     <= in_pos_z;
      pow_r   <= in_seg_power;
      param_r <= in_seg_param;
      qt_r    <= in_query_time;
    end
    if (cmd.decode) begin
      sq_cnt_r <= '0;
      sq_r     <= '0;
      acc_r    <= '0;
      wi_r     <= (pidx_r > n_idx) ? n_idx : pidx_r;
      phase_r  <= PH_BACK;
    end
    if (cmd.sq_step) begin
      sq_r     <= sq_mag * sq_mag;
      acc_r    <= acc_r + SQ_W'(sq_r);
      sq_cnt_r <= sq_cnt_r + 2'd1;
    end
    // bit-by-bit integer root
    if (cmd.root_load) begin
      op_r  <= acc_r;
      res_r <= '0;
      one_r <= SQ_W'(1) << (2 * (ROOT_STEPS - 1));
    end else if (root_cnt_r != '0) begin
      if (root_ge) begin
        op_r  <= op_r - root_sum[SQ_W-1:0];
        res_r <= (res_r >> 1) + one_r;
      end else begin
        res_r <= res_r >> 1;
      end
      one_r <= one_r >> 2;
    end
    // divider loads and steps
    if (cmd.dur_load) begin
      rem_r <= '0;
      num_r <= {1'b0, res_r[ROOT_W-1:0], {EL_HALF{1'b0}}};
      q_r   <= '0;
      d_r   <= param_r;
    end else if (cmd.ax_load) begin
      rem_r <= prod_r[PROD_W-1:POS_W];
      num_r <= {prod_r[POS_W-1:0], {(DIV_W - POS_W){1'b0}}};
      q_r   <= '0;
      d_r   <= dt_r;
    end else if (div_cnt_r != '0) begin
      rem_r <= div_ge ? div_sub[TIME_W-1:0] : div_rs[TIME_W-1:0];
      num_r <= num_r << 1;
      q_r   <= {q_r[DIV_W-2:0], div_ge};
    end
    // index walk
    if (cmd.walk_ev) begin
      if (walk_back) begin
        wi_r <= wi_r - AW'(1);
      end else if (walk_fwd) begin
        wi_r    <= wi_r + AW'(1);
        phase_r <= PH_FWD;
      end else if (walk_skip) begin
        wi_r    <= wi_r + AW'(1);
        phase_r <= PH_SKIP;
      end
    end
    if (cmd.prv_rd) begin
      cur_r <= rd_row;
    end
    if (cmd.prv_cap) begin
      prv_r <= rd_row;
    end
    if (cmd.select) begin
      dt_r   <= sel_dt;
      el_r   <= sel_el;
      axis_r <= 2'd0;
    end
    // elapsed times displacement in two partial products
    if (cmd.mul_lo) begin
      prod_r <= PROD_W'(pp_lo);
    end
    if (cmd.mul_hi) begin
      prod_r <= prod_r + {pp_hi, {EL_HALF{1'b0}}};
    end
    if (cmd.ax_store) begin
      axis_r <= axis_r + 2'd1;
    end
    if (cmd.res_load) begin
      out_status_r <= cmd.res_status;
      if (func_r) begin
        out_x_r   <= held_x_r;
        out_y_r   <= held_y_r;
        out_z_r   <= held_z_r;
        out_pow_r <= (cmd.res_status == STAT_BEAM_OFF) ? '0 : held_pow_r;
      end else begin
        out_x_r   <= '0;
        out_y_r   <= '0;
        out_z_r   <= '0;
        out_pow_r <= '0;
      end
    end
  end

  assign out_tvalid     = out_valid_r;
  assign out_status     = out_status_r;
  assign out_beam_x     = out_x_r;
  assign out_beam_y     = out_y_r;
  assign out_beam_z     = out_z_r;
  assign out_beam_power = out_pow_r;

  `SPBI_ASSERT_NXT(a_count_step, cmd.commit, count_r == $past(count_r) + CW'(1))
  `SPBI_ASSERT_IMP(a_index_range, count_r > CW'(1), {1'b0, pidx_r} < count_r)
  `SPBI_ASSERT_IMP(a_div_nonzero, div_cnt_r != '0, d_r != '0)

endmodule

// File: rtl/scan_path_beam_interpolator.sv
`timescale 1ns / 1ps

// Scan-path beam interpolator. Append requests store a line move or a point
// dwell with its cumulative end time; query requests return the interpolated
// beam centre and power at a given time. One request is worked at a time; a
// new one is taken while the previous result waits in the output register.
// A line append runs the squaring of the axis differences, a 33-step
// bit-serial root and a 55-step bit-serial divide; a dwell append skips
// them. A query walks the table index with one table read per step; on a
// line move it then runs the 32-step shared divider once per axis, while a
// query that lands on a dwell or a zero-length move skips it, and one past
// the end goes straight to the result. Output stalls delay the result.
// Segment 0 is the origin and reads as zero; the table needs no clearing
// after reset.
module scan_path_beam_interpolator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // pos_x, pos_y, pos_z, seg_power, seg_param, query_time
  input  logic [spbi_pkg::IN_DATA_W-1:0]    in_tdata,
  // func, seg_mode
  input  logic [spbi_pkg::USER_W-1:0]       in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // beam_x, beam_y, beam_z, beam_power
  output logic [spbi_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status
  output logic [spbi_pkg::USER_W-1:0]       out_tuser
);
  import spbi_pkg::*;

  cmd_t             cmd;
  stat_t            st;
  status_t          status;
  logic [POS_W-1:0] bx, by, bz;
  logic [POW_W-1:0] bp;

  spbi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  spbi_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_func        (in_tuser[0]),
    .in_seg_mode    (in_tuser[1]),
    .in_pos_x       (in_tdata[31:0]),
    .in_pos_y       (in_tdata[63:32]),
    .in_pos_z       (in_tdata[95:64]),
    .in_seg_power   (in_tdata[119:96]),
    .in_seg_param   (in_tdata[159:120]),
    .in_query_time  (in_tdata[199:160]),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_status     (status),
    .out_beam_x     (bx),
    .out_beam_y     (by),
    .out_beam_z     (bz),
    .out_beam_power (bp)
  );

  assign out_tdata = {bp, bz, by, bx};
  assign out_tuser = status;

endmodule

// File: dv/scan_path_beam_interpolator_tb.sv
`timescale 1ns / 1ps

module scan_path_beam_interpolator_tb;
  import spbi_pkg::*;

  localparam logic [TIME_W-1:0] T_MASK = {TIME_W{1'b1}};

  typedef struct {
    logic              func;
    logic              mode;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [POS_W-1:0]  z;
    logic [POW_W-1:0]  power;
    logic [TIME_W-1:0] param;
    logic [TIME_W-1:0] qtime;
  } beam_req_t;

  typedef struct {
    status_t          status;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
    logic [POW_W-1:0] power;
  } beam_res_t;

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;
  localparam logic MODE_LINE   = 1'b0;
  localparam logic MODE_DWELL  = 1'b1;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [USER_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [USER_W-1:0] out_tuser;

  // predictor state: segment table, walk index, held beam
  logic [POS_W-1:0]  seg_x [MAX_SEGMENTS];
  logic [POS_W-1:0]  seg_y [MAX_SEGMENTS];
  logic [POS_W-1:0]  seg_z [MAX_SEGMENTS];
  logic [POW_W-1:0]  seg_pow [MAX_SEGMENTS];
  logic              seg_mode [MAX_SEGMENTS];
  logic [TIME_W-1:0] seg_param [MAX_SEGMENTS];
  logic [TIME_W-1:0] seg_end [MAX_SEGMENTS];
  int unsigned       seg_count;
  int unsigned       walk_idx;
  logic [TIME_W-1:0] powered_until;
  logic [POS_W-1:0]  hold_x, hold_y, hold_z;
  logic [POW_W-1:0]  hold_pow;

  beam_res_t expected_beam_q[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned appends_sent, queries_sent;
  int unsigned send_idle_pct, recv_stall_pct;

  scan_path_beam_interpolator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #100ms;
    $display("timeout: %0d results outstanding", expected_beam_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // floor of the square root of a wide value
  function automatic logic [127:0] root_floor(input logic [127:0] v);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  // one axis of the linear blend, truncated toward zero
  function automatic logic [POS_W-1:0] blend_axis(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b,
                                                  input logic [TIME_W-1:0] el,
                                                  input logic [TIME_W-1:0] dt);
    longint p0, dx;
    logic [127:0] mag, q;
    p0 = longint'(signed'(a));
    dx = longint'(signed'(b)) - p0;
    mag = (dx < 0) ? 128'(-dx) : 128'(dx);
    q = (mag * 128'(el)) / 128'(dt);
    return (dx < 0) ? POS_W'(p0 - longint'(q)) : POS_W'(p0 + longint'(q));
  endfunction

  function automatic status_t append_segment(input beam_req_t r);
    int unsigned k;
    logic [127:0] sq, dur, t;
    longint d;
    k = seg_count;
    if (k >= MAX_SEGMENTS) return STAT_FULL;
    if (r.mode == MODE_LINE && r.param == '0) return STAT_ZERO_SPEED;
    seg_x[k] = r.x;
    seg_y[k] = r.y;
    seg_z[k] = r.z;
    seg_pow[k] = r.power;
    seg_mode[k] = r.mode;
    seg_param[k] = r.param;
    if (r.mode == MODE_DWELL) begin
      dur = 128'(r.param);
    end else begin
      sq = '0;
      d = longint'(signed'(r.x)) - longint'(signed'(seg_x[k-1]));
      sq += 128'(d < 0 ? -d : d) * 128'(d < 0 ? -d : d);
      d = longint'(signed'(r.y)) - longint'(signed'(seg_y[k-1]));
      sq += 128'(d < 0 ? -d : d) * 128'(d < 0 ? -d : d);
      d = longint'(signed'(r.z)) - longint'(signed'(seg_z[k-1]));
      sq += 128'(d < 0 ? -d : d) * 128'(d < 0 ? -d : d);
      dur = (root_floor(sq) << 20) / 128'(r.param);
    end
    if (dur > 128'(T_MASK)) dur = 128'(T_MASK);
    t = 128'(seg_end[k-1]) + dur;
    if (t > 128'(T_MASK)) t = 128'(T_MASK);
    seg_end[k] = TIME_W'(t);
    if (r.power != '0) powered_until = TIME_W'(t);
    seg_count = k + 1;
    return STAT_OK;
  endfunction

  function automatic status_t query_beam(input logic [TIME_W-1:0] t);
    int unsigned n, i;
    logic [TIME_W-1:0] prev, dt, el;
    n = seg_count - 1;
    i = walk_idx;
    if (seg_count <= 1 || t > powered_until) begin
      hold_pow = '0;
      return STAT_BEAM_OFF;
    end
    if (i > n) i = n;
    while (i > 0 && seg_end[i] > t) i--;
    while (i < n && seg_end[i] < t) i++;
    while (i < n && seg_mode[i] == MODE_DWELL && seg_param[i] == '0) i++;
    if (i < 1) i = 1;
    walk_idx = i;
    prev = seg_end[i-1];
    if (seg_mode[i] == MODE_DWELL) begin
      hold_x = seg_x[i];
      hold_y = seg_y[i];
      hold_z = seg_z[i];
    end else begin
      dt = seg_end[i] - prev;
      if (dt != '0) begin
        el = (t > prev) ? t - prev : '0;
        if (el > dt) el = dt;
        hold_x = blend_axis(seg_x[i-1], seg_x[i], el, dt);
        hold_y = blend_axis(seg_y[i-1], seg_y[i], el, dt);
        hold_z = blend_axis(seg_z[i-1], seg_z[i], el, dt);
      end else begin
        hold_x = seg_x[i-1];
        hold_y = seg_y[i-1];
        hold_z = seg_z[i-1];
      end
    end
    hold_pow = (t > prev) ? seg_pow[i] : seg_pow[i-1];
    return STAT_OK;
  endfunction

  function automatic beam_res_t predict_beam(input beam_req_t r);
    beam_res_t e;
    e = '{STAT_OK, '0, '0, '0, '0};
    if (r.func == FUNC_APPEND) begin
      e.status = append_segment(r);
    end else begin
      e.status = query_beam(r.qtime);
      e.x = hold_x;
      e.y = hold_y;
      e.z = hold_z;
      e.power = hold_pow;
    end
    return e;
  endfunction

  // drive one request and wait for it to be taken
  task automatic send_req(input beam_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= {r.qtime, r.param, r.power, r.z, r.y, r.x};
    in_tuser <= {r.mode, r.func};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!(in_tvalid && in_tready)) @(posedge clk);
    expected_beam_q.insert(expected_beam_q.size(), predict_beam(r));
    if (r.func == FUNC_APPEND) appends_sent++;
    else queries_sent++;
  endtask

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  function automatic beam_req_t mk_append(input logic mode, input logic [POS_W-1:0] x,
                                          input logic [POS_W-1:0] y,
                                          input logic [POS_W-1:0] z,
                                          input logic [POW_W-1:0] p,
                                          input logic [TIME_W-1:0] param);
    beam_req_t r;
    r.func = FUNC_APPEND;
    r.mode = mode;
    r.x = x;
    r.y = y;
    r.z = z;
    r.power = p;
    r.param = param;
    r.qtime = rand_time();
    return r;
  endfunction

  function automatic beam_req_t mk_query(input logic [TIME_W-1:0] t);
    beam_req_t r;
    r.func = FUNC_QUERY;
    r.mode = 1'($urandom_range(1));
    r.x = $urandom;
    r.y = $urandom;
    r.z = $urandom;
    r.power = POW_W'($urandom);
    r.param = rand_time();
    r.qtime = t;
    return r;
  endfunction

  // random segment with mostly modest coordinates and speeds
  function automatic beam_req_t rand_append();
    logic mode;
    logic [POS_W-1:0] c [3];
    logic [TIME_W-1:0] param;
    logic [POW_W-1:0] p;
    mode = ($urandom_range(99) < 30) ? MODE_DWELL : MODE_LINE;
    for (int a = 0; a < 3; a++)
      c[a] = ($urandom_range(9) == 0) ? $urandom : POS_W'(int'($urandom_range(4000000)) - 2000000);
    p = ($urandom_range(5) == 0) ? '0 : POW_W'($urandom);
    case ($urandom_range(9))
      0: param = '0;
      1: param = rand_time();
      default: param = (mode == MODE_DWELL) ? TIME_W'($urandom_range(1 << 24))
                                            : TIME_W'($urandom_range(1 << 26, 1 << 16));
    endcase
    return mk_append(mode, c[0], c[1], c[2], p, param);
  endfunction

  // query time mostly on the powered path, sometimes past it
  function automatic beam_req_t rand_query();
    logic [TIME_W-1:0] t;
    case ($urandom_range(9))
      0: t = rand_time();
      1: t = powered_until + TIME_W'($urandom_range(3));
      2: t = seg_end[$urandom_range(seg_count - 1)];
      default: t = (powered_until == T_MASK) ? rand_time()
                                              : rand_time() % (powered_until + 1);
    endcase
    return mk_query(t);
  endfunction

  // result check
  always @(posedge clk) begin
    beam_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_beam_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: tuser %0d tdata %h",
                                       out_tuser, out_tdata);
      end else begin
        e = expected_beam_q.pop_front();
        if (out_tuser !== e.status || out_tdata[31:0] !== e.x ||
            out_tdata[63:32] !== e.y || out_tdata[95:64] !== e.z ||
            out_tdata[119:96] !== e.power) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at result %0d: exp st %0d x %h y %h z %h p %h,",
                      " got st %0d x %h y %h z %h p %h"},
                     results_seen, e.status, e.x, e.y, e.z, e.power, out_tuser,
                     out_tdata[31:0], out_tdata[63:32], out_tdata[95:64],
                     out_tdata[119:96]);
        end
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic test_empty_path();
    send_req(mk_query('0));
    send_req(mk_query(T_MASK));
    send_req(mk_append(MODE_LINE, 32'h1_0000, '0, '0, 24'h100, '0));
  endtask

  task automatic test_directed_segments();
    // line, zero-length dwell, powered dwell, unpowered line, extremes
    send_req(mk_append(MODE_LINE, 32'h0003_0000, 32'h0004_0000, '0, 24'h000100,
                       40'h10_0000));
    send_req(mk_append(MODE_DWELL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       24'hFFFFFF, '0));
    send_req(mk_append(MODE_DWELL, 32'h0005_0000, 32'hFFFF_0000, 32'h0001_0000,
                       24'h000080, 40'h8_0000));
    send_req(mk_append(MODE_LINE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '0,
                       T_MASK));
    send_req(mk_append(MODE_LINE, 32'hFFFF_FFFF, '0, 32'h0000_8000, 24'h000001,
                       40'h1_0000));
    send_req(mk_query('0));
    send_req(mk_query(40'h2_0000));
    send_req(mk_query(40'h50_0000));
    send_req(mk_query(seg_end[1]));
    send_req(mk_query(seg_end[3]));
    send_req(mk_query(powered_until));
    send_req(mk_query(powered_until + 1));
    send_req(mk_query(40'h1));
    // hold until the block has drained
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (expected_beam_q.size() == 0);
    send_req(mk_query(powered_until >> 1));
    send_req(mk_query(T_MASK));
  endtask

  task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input int unsigned items);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int unsigned k = 0; k < items; k++) begin
      if ($urandom_range(99) < 35 && seg_count < MAX_SEGMENTS - 40) send_req(rand_append());
      else send_req(rand_query());
    end
  endtask

  task automatic test_table_full();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (seg_count < MAX_SEGMENTS) send_req(rand_append());
    send_req(rand_append());
    send_req(mk_append(MODE_DWELL, '0, '0, '0, 24'h1, '0));
    for (int k = 0; k < 6; k++) send_req(rand_query());
    send_req(mk_query(seg_end[1]));
    send_req(mk_query(seg_end[MAX_SEGMENTS - 1]));
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    mismatches = 0;
    results_seen = 0;
    appends_sent = 0;
    queries_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      seg_x[k] = '0;
      seg_y[k] = '0;
      seg_z[k] = '0;
      seg_pow[k] = '0;
      seg_mode[k] = MODE_LINE;
      seg_param[k] = '0;
      seg_end[k] = '0;
    end
    seg_count = 1;
    walk_idx = 0;
    powered_until = '0;
    hold_x = '0;
    hold_y = '0;
    hold_z = '0;
    hold_pow = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_path();
    test_directed_segments();
    test_random_phase(0, 0, 105);
    test_random_phase(67, 0, 105);
    test_random_phase(0, 67, 105);
    test_random_phase(38, 38, 105);
    test_table_full();

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (expected_beam_q.size() == 0);
    repeat (600) @(posedge clk);

    $display("covered %0d appends and %0d queries, %0d results checked, table at %0d",
             appends_sent, queries_sent, results_seen, seg_count);
    $display("idling phases: none, sender, receiver, both; mismatches %0d", mismatches);
    if (mismatches == 0 && expected_beam_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/spbi_pkg.sv
rtl/spbi_ram.sv
rtl/spbi_ctrl.sv
rtl/spbi_dpath.sv
rtl/scan_path_beam_interpolator.sv
dv/scan_path_beam_interpolator_tb.sv
